// File: hw/rtl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Types, condition codes and field codes shared by the condition branch
// resolver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

  // condition field codes (opcode bits 11..8)
  localparam logic [3:0] CC_T  = 4'd0;
  localparam logic [3:0] CC_F  = 4'd1;
  localparam logic [3:0] CC_HI = 4'd2;
  localparam logic [3:0] CC_LS = 4'd3;
  localparam logic [3:0] CC_CC = 4'd4;
  localparam logic [3:0] CC_CS = 4'd5;
  localparam logic [3:0] CC_NE = 4'd6;
  localparam logic [3:0] CC_EQ = 4'd7;
  localparam logic [3:0] CC_VC = 4'd8;
  localparam logic [3:0] CC_VS = 4'd9;
  localparam logic [3:0] CC_PL = 4'd10;
  localparam logic [3:0] CC_MI = 4'd11;
  localparam logic [3:0] CC_GE = 4'd12;
  localparam logic [3:0] CC_LT = 4'd13;
  localparam logic [3:0] CC_GT = 4'd14;
  localparam logic [3:0] CC_LE = 4'd15;

  // mode codes
  localparam logic MODE_BRANCH = 1'b0;
  localparam logic MODE_COND   = 1'b1;

  // byte displacement codes that select an extension
  localparam logic [7:0] DISP_WORD = 8'h00;
  localparam logic [7:0] DISP_LONG = 8'hff;

  // type field codes (opcode bits 5..3)
  localparam logic [2:0] TYPE_DBCC = 3'd1;
  localparam logic [2:0] TYPE_EXT  = 3'd7;

  // register field codes under the extended type
  localparam logic [2:0] REG_TRAP_WORD = 3'd2;
  localparam logic [2:0] REG_TRAP_LONG = 3'd3;
  localparam logic [2:0] REG_TRAP_NONE = 3'd4;

  localparam logic [7:0]  SET_ONES    = 8'hff;
  localparam logic [15:0] COUNT_EXPIRED = 16'hffff;

  // one input item
  typedef struct packed {
    logic               mode;
    logic [15:0]        opcode;
    logic [31:0]        pc;
    logic signed [15:0] ext_word;
    logic signed [31:0] ext_long;
    logic [15:0]        counter_in;
    logic               flag_n;
    logic               flag_z;
    logic               flag_v;
    logic               flag_c;
  } in_t;

  // one result item
  typedef struct packed {
    logic [31:0] next_pc;
    logic        taken;
    logic        push_valid;
    logic [31:0] push_value;
    logic        counter_write;
    logic [15:0] counter_value;
    logic        set_byte_write;
    logic [7:0]  set_byte;
    logic        trap;
    logic        illegal;
    logic        traced;
  } out_t;

  // evaluate a condition code against the flags
  function automatic logic cond_true(input logic [3:0] cc, input logic n, input logic z,
                                     input logic v, input logic c);
    logic r;
    case (cc)
      CC_T:    r = 1'b1;
      CC_F:    r = 1'b0;
      CC_HI:   r = !c && !z;
      CC_LS:   r = c || z;
      CC_CC:   r = !c;
      CC_CS:   r = c;
      CC_NE:   r = !z;
      CC_EQ:   r = z;
      CC_VC:   r = !v;
      CC_VS:   r = v;
      CC_PL:   r = !n;
      CC_MI:   r = n;
      CC_GE:   r = (n == v);
      CC_LT:   r = (n != v);
      CC_GT:   r = (n == v) && !z;
      CC_LE:   r = z || (n != v);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cbr_if.sv
// ----------------------------------------------------------------------------
// cbr_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbr_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [15:0]        opcode;
  logic [31:0]        pc;
  logic signed [15:0] ext_word;
  logic signed [31:0] ext_long;
  logic [15:0]        counter_in;
  logic               flag_n;
  logic               flag_z;
  logic               flag_v;
  logic               flag_c;

  modport source (
    output valid, mode, opcode, pc, ext_word, ext_long, counter_in,
           flag_n, flag_z, flag_v, flag_c,
    input  ready
  );
  modport sink (
    input  valid, mode, opcode, pc, ext_word, ext_long, counter_in,
           flag_n, flag_z, flag_v, flag_c,
    output ready
  );
endinterface

interface cbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        taken;
  logic        push_valid;
  logic [31:0] push_value;
  logic        counter_write;
  logic [15:0] counter_value;
  logic        set_byte_write;
  logic [7:0]  set_byte;
  logic        trap;
  logic        illegal;
  logic        traced;

  modport source (
    output valid, next_pc, taken, push_valid, push_value, counter_write,
           counter_value, set_byte_write, set_byte, trap, illegal, traced,
    input  ready
  );
  modport sink (
    input  valid, next_pc, taken, push_valid, push_value, counter_write,
           counter_value, set_byte_write, set_byte, trap, illegal, traced,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/cbr_resolve.sv
// ----------------------------------------------------------------------------
// cbr_resolve
// Combinational decode of one conditional instruction into its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbr_resolve (
  input  cbr_pkg::in_t  item_i,
  output cbr_pkg::out_t res_o
);

  logic [3:0]  cc;
  logic [2:0]  typ;
  logic [2:0]  rg;
  logic [7:0]  low;
  logic        ok;
  logic [31:0] word_disp;
  logic [31:0] disp;
  logic [31:0] after;
  logic [15:0] dec_cnt;

  assign cc        = item_i.opcode[11:8];
  assign typ       = item_i.opcode[5:3];
  assign rg        = item_i.opcode[2:0];
  assign low       = item_i.opcode[7:0];
  assign ok        = cbr_pkg::cond_true(cc, item_i.flag_n, item_i.flag_z,
                                        item_i.flag_v, item_i.flag_c);
  assign word_disp = {{16{item_i.ext_word[15]}}, item_i.ext_word};
  assign dec_cnt   = item_i.counter_in - 16'd1;

  // displacement select for the branch family
  always_comb begin
    case (low)
      cbr_pkg::DISP_WORD: begin
        disp  = word_disp;
        after = item_i.pc + 32'd2;
      end
      cbr_pkg::DISP_LONG: begin
        disp  = item_i.ext_long;
        after = item_i.pc + 32'd4;
      end
      default: begin
        disp  = {{24{low[7]}}, low};
        after = item_i.pc;
      end
    endcase
  end

  // result per instruction family
  always_comb begin
    res_o = '0;
    if (item_i.mode == cbr_pkg::MODE_BRANCH) begin
      if (cc == cbr_pkg::CC_T || cc == cbr_pkg::CC_F || ok) begin
        res_o.next_pc = item_i.pc + disp;
        res_o.taken   = 1'b1;
        res_o.traced  = 1'b1;
        if (cc == cbr_pkg::CC_F) begin
          // subroutine call pushes the return address
          res_o.push_valid = 1'b1;
          res_o.push_value = after;
        end
      end else begin
        res_o.next_pc = after;
      end
    end else if (typ == cbr_pkg::TYPE_DBCC) begin
      res_o.next_pc = item_i.pc + 32'd2;
      if (!ok) begin
        res_o.counter_write = 1'b1;
        res_o.counter_value = dec_cnt;
        if (dec_cnt != cbr_pkg::COUNT_EXPIRED) begin
          res_o.next_pc = item_i.pc + word_disp;
          res_o.taken   = 1'b1;
          res_o.traced  = 1'b1;
        end
      end
    end else if (typ == cbr_pkg::TYPE_EXT && (rg inside {[3'd2:3'd7]})) begin
      case (rg)
        cbr_pkg::REG_TRAP_WORD: begin
          res_o.next_pc = item_i.pc + 32'd2;
          res_o.trap    = ok;
        end
        cbr_pkg::REG_TRAP_LONG: begin
          res_o.next_pc = item_i.pc + 32'd4;
          res_o.trap    = ok;
        end
        cbr_pkg::REG_TRAP_NONE: begin
          res_o.next_pc = item_i.pc;
          res_o.trap    = ok;
        end
        default: begin
          // register field with no meaning under the trap type
          res_o.next_pc = item_i.pc;
          res_o.illegal = 1'b1;
        end
      endcase
    end else begin
      // set byte on condition, absolute forms included
      res_o.next_pc        = item_i.pc;
      res_o.set_byte_write = 1'b1;
      res_o.set_byte       = ok ? cbr_pkg::SET_ONES : 8'h00;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/condition_branch_resolver.sv
// ----------------------------------------------------------------------------
// condition_branch_resolver
// Branch and condition-code resolution unit with registered input and result.
// ----------------------------------------------------------------------------
// Accepts one conditional instruction (branch, DBcc, TRAPcc or Scc) per clock
// cycle and returns exactly one result transaction for each. The path runs
// through one input register, then the condition decode and one 32-bit
// address add into the result register. Both stages hold their transaction
// under backpressure and refill in the cycle they drain, so throughput is
// one item per cycle while the sink keeps ready high. There are no
// configuration registers and no internal state besides the two pipeline
// stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module condition_branch_resolver (
  input  wire        clk_i,
  input  wire        rst_ni,
  cbr_in_if.sink     in_i,
  cbr_out_if.source  out_o
);

  logic          s1_valid_q;
  cbr_pkg::in_t  s1_q;
  cbr_pkg::in_t  s1_d;
  logic          s2_valid_q;
  cbr_pkg::out_t s2_q;
  cbr_pkg::out_t s2_d;
  logic          s1_ready;
  logic          s2_ready;

  // stage handshakes
  assign s2_ready   = !s2_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  assign s1_d.mode       = in_i.mode;
  assign s1_d.opcode     = in_i.opcode;
  assign s1_d.pc         = in_i.pc;
  assign s1_d.ext_word   = in_i.ext_word;
  assign s1_d.ext_long   = in_i.ext_long;
  assign s1_d.counter_in = in_i.counter_in;
  assign s1_d.flag_n     = in_i.flag_n;
  assign s1_d.flag_z     = in_i.flag_z;
  assign s1_d.flag_v     = in_i.flag_v;
  assign s1_d.flag_c     = in_i.flag_c;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_q <= s1_d;
    end
  end

  cbr_resolve u_resolve (
    .item_i (s1_q),
    .res_o  (s2_d)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_o.valid          = s2_valid_q;
  assign out_o.next_pc        = s2_q.next_pc;
  assign out_o.taken          = s2_q.taken;
  assign out_o.push_valid     = s2_q.push_valid;
  assign out_o.push_value     = s2_q.push_value;
  assign out_o.counter_write  = s2_q.counter_write;
  assign out_o.counter_value  = s2_q.counter_value;
  assign out_o.set_byte_write = s2_q.set_byte_write;
  assign out_o.set_byte       = s2_q.set_byte;
  assign out_o.trap           = s2_q.trap;
  assign out_o.illegal        = s2_q.illegal;
  assign out_o.traced         = s2_q.traced;

  // a stalled input stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input stage lost a stalled transaction");

  // a return push only comes with a taken branch
  a_push_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.push_valid) |-> (s2_q.taken && s2_q.traced))
    else $error("push without taken branch");

  // at most one kind of side effect per result
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $onehot0({s2_q.push_valid, s2_q.counter_write,
                             s2_q.set_byte_write, s2_q.trap, s2_q.illegal}))
    else $error("more than one side effect in a result");

  // an illegal encoding never transfers control
  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.illegal) |-> (!s2_q.taken && !s2_q.traced))
    else $error("illegal encoding marked as taken");

endmodule

`default_nettype wire
